@@ sv/circular_deque_assert.svh @@
// Assertion macros shared by the deque modules.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH
`ifndef SYNTH
`define CDQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("circular_deque assertion failed");
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("circular_deque assertion failed");
`else
`define CDQ_ASSERT(lbl, clk, rst_n, prop)
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/cdq_pkg.sv @@
package cdq_pkg;

	localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FN_PUSH_REAR  = 3'd1;
	localparam logic [2:0] FN_POP_FRONT  = 3'd2;
	localparam logic [2:0] FN_POP_REAR   = 3'd3;
	localparam logic [2:0] FN_PEEK_FRONT = 3'd4;
	localparam logic [2:0] FN_PEEK_REAR  = 3'd5;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_OVERFLOW  = 2'd1;
	localparam logic [1:0] STS_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
	} cdq_in_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [1:0]         status;
		logic [3:0]         occupancy;
	} cdq_out_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic show;
	} cdq_cmd_t;

endpackage

@@ sv/circular_deque.sv @@
// Double-ended queue of DEPTH 32-bit words held in a circular store. An operation is
// taken when start is high while busy is low; it then runs in order: the beat is
// captured, the store is written once or read once into a register, and the result
// is shown for one cycle with done high; no new operation is taken until it has been
// shown. The receiver cannot hold a result off and must take it in the cycle that
// done is high. A push into a full deque is refused with overflow, a pop or peek of an
// empty deque returns underflow, and the store needs no clearing after reset.
module circular_deque #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cdq_pkg::cdq_in_t  req,
	output logic              done,
	output cdq_pkg::cdq_out_t rsp
);

	cdq_pkg::cdq_cmd_t cmd;

	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	cdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	assign done = cmd.show;

endmodule

@@ sv/cdq_ctrl.sv @@
`include "circular_deque_assert.svh"

module cdq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output cdq_pkg::cdq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy     = (state_q != S_IDLE);
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);
	assign cmd.show = (state_q == S_DONE);

	`CDQ_ASSERT_NEXT(a_accept_execs, clk, arst_n, cmd.load, cmd.exec)
	`CDQ_ASSERT_NEXT(a_exec_shows, clk, arst_n, cmd.exec, cmd.show && busy)
	`CDQ_ASSERT_NEXT(a_show_single, clk, arst_n, cmd.show, !cmd.show && !busy)

endmodule

@@ sv/cdq_datapath.sv @@
`include "circular_deque_assert.svh"

module cdq_datapath #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cdq_pkg::cdq_cmd_t cmd,
	input  cdq_pkg::cdq_in_t  req,
	output cdq_pkg::cdq_out_t rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [2:0]         func_q;
	logic signed [31:0] value_q;
	logic [IW-1:0]      head_q;
	logic [IW-1:0]      tail_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] rd_q;
	logic [1:0]         status_q;
	logic               zero_q;
	logic signed [31:0] mem [DEPTH];

	logic [IW-1:0] head_d;
	logic [IW-1:0] tail_d;
	logic [CW-1:0] count_d;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic [1:0]    status_d;
	logic          zero_d;
	logic          empty;
	logic          full;

	function automatic logic [IW-1:0] slot_up(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [IW-1:0] slot_down(input logic [IW-1:0] i);
		return (i == '0) ? IW'(DEPTH - 1) : i - IW'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		wr_en    = 1'b0;
		wr_addr  = '0;
		rd_addr  = head_q;
		status_d = cdq_pkg::STS_OK;
		zero_d   = 1'b1;
		case (func_q) inside
			cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_REAR: begin
				if (full) begin
					status_d = cdq_pkg::STS_OVERFLOW;
				end else if (empty) begin
					head_d  = '0;
					tail_d  = '0;
					wr_en   = 1'b1;
					wr_addr = '0;
					count_d = CW'(1);
				end else if (func_q == cdq_pkg::FN_PUSH_FRONT) begin
					head_d  = slot_down(head_q);
					wr_en   = 1'b1;
					wr_addr = head_d;
					count_d = count_q + CW'(1);
				end else begin
					tail_d  = slot_up(tail_q);
					wr_en   = 1'b1;
					wr_addr = tail_d;
					count_d = count_q + CW'(1);
				end
			end
			cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_REAR,
			cdq_pkg::FN_PEEK_FRONT, cdq_pkg::FN_PEEK_REAR: begin
				if (empty) begin
					status_d = cdq_pkg::STS_UNDERFLOW;
				end else begin
					zero_d = 1'b0;
					if (func_q == cdq_pkg::FN_POP_FRONT || func_q == cdq_pkg::FN_PEEK_FRONT) begin
						rd_addr = head_q;
					end else begin
						rd_addr = tail_q;
					end
					if (func_q == cdq_pkg::FN_POP_FRONT || func_q == cdq_pkg::FN_POP_REAR) begin
						count_d = count_q - CW'(1);
						if (count_q == CW'(1)) begin
							head_d = '0;
							tail_d = '0;
						end else if (func_q == cdq_pkg::FN_POP_FRONT) begin
							head_d = slot_up(head_q);
						end else begin
							tail_d = slot_down(tail_q);
						end
					end
				end
			end
			default: begin
				zero_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= req.func;
			value_q <= req.value;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			zero_q   <= zero_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) mem[wr_addr] <= value_q;
		if (cmd.exec) rd_q <= mem[rd_addr];
	end

	assign rsp.data      = zero_q ? 32'sd0 : rd_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = 4'(count_q);

	`CDQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`CDQ_ASSERT(a_empty_home, clk, arst_n, (count_q == '0) |-> (head_q == '0 && tail_q == '0))
	`CDQ_ASSERT(a_single_same, clk, arst_n, (count_q == CW'(1)) |-> (head_q == tail_q))
	`CDQ_ASSERT_NEXT(a_overflow_full, clk, arst_n, cmd.exec && status_d == cdq_pkg::STS_OVERFLOW, count_q == CW'(DEPTH))

endmodule
